@@ hw/rtl/mevq_pkg.sv @@
// ----------------------------------------------------------------------------
// mevq_pkg
// Types and constants shared by the masked event queue modules.
// ----------------------------------------------------------------------------
package mevq_pkg;

    localparam int SlotW = 8;
    localparam logic [31:0] RepeatStep = 32'h0001_0000;

    typedef enum logic [2:0] {
        OP_RAW   = 3'd0,
        OP_KEY   = 3'd1,
        OP_MOUSE = 3'd2,
        OP_GET   = 3'd3,
        OP_PEEK  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        REG_KEY_DOWN = 3'd0,
        REG_KEY_REP  = 3'd1,
        REG_SHIFT    = 3'd2,
        REG_CTRL     = 3'd3,
        REG_ALT      = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [31:0]        source_id;
        logic [31:0]        event_type;
        logic [31:0]        payload;
        logic [31:0]        modifier_bits;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        timestamp;
        logic [31:0]        type_mask;
    } in_item_t;

    typedef struct packed {
        logic               success;
        logic [31:0]        out_source_id;
        logic [31:0]        out_type;
        logic [31:0]        out_message;
        logic [31:0]        out_modifiers;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [31:0]        out_time;
    } out_item_t;

    typedef struct packed {
        logic [SlotW-1:0] id;
        logic [31:0]      src;
        logic [31:0]      etype;
        logic [31:0]      msg;
        logic [31:0]      mods;
        logic [15:0]      x;
        logic [15:0]      y;
        logic [31:0]      stamp;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic incr;
    } cell_ctl_t;

endpackage

@@ hw/rtl/mevq_cell.sv @@
// ----------------------------------------------------------------------------
// mevq_cell
// One queue position: loads a new entry, takes its neighbor's entry, or bumps
// the repeat count of the entry it holds.
// ----------------------------------------------------------------------------
module mevq_cell (
    input  logic                         clk,
    input  mevq_pkg::cell_ctl_t          ctl,
    input  mevq_pkg::entry_t             nbr,
    input  mevq_pkg::entry_t             fresh,
    input  logic [mevq_pkg::SlotW-1:0]   rep_id,
    output mevq_pkg::entry_t             entry
);

    mevq_pkg::entry_t entry_reg;
    mevq_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctl.load)
        begin
            entry_next = fresh;
        end
        else if (ctl.shift)
        begin
            entry_next = nbr;
        end
        else if (ctl.incr && (entry_reg.id == rep_id))
        begin
            entry_next.msg = entry_reg.msg + mevq_pkg::RepeatStep;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ hw/rtl/masked_event_queue.sv @@
// ----------------------------------------------------------------------------
// masked_event_queue
// Age-ordered event store held in a chain of cells, with masked get and peek.
// ----------------------------------------------------------------------------
// Entries sit in age order in a chain of QUEUE_DEPTH cells, oldest in cell 0.
// Posts (raw, key, mouse) and unknown operations return their result from the
// output register loaded at the transfer. Get and peek rotate the whole chain
// once in ST_SCAN to find the oldest matching entry; a get then unlinks it in
// ST_FIN, which waits while the output is stalled. Slot numbers come from a
// free stack kept beside the chain. One item is in flight at a time.
module masked_event_queue #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mevq_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mevq_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SW = mevq_pkg::SlotW;
    localparam logic [SW-1:0] Depth = SW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] LastIdx = SW'(QUEUE_DEPTH - 1);

    localparam logic [2:0] REG_KEY_DOWN_IDX = 3'(mevq_pkg::REG_KEY_DOWN);
    localparam logic [2:0] REG_KEY_REP_IDX  = 3'(mevq_pkg::REG_KEY_REP);
    localparam logic [2:0] REG_SHIFT_IDX    = 3'(mevq_pkg::REG_SHIFT);
    localparam logic [2:0] REG_CTRL_IDX     = 3'(mevq_pkg::REG_CTRL);
    localparam logic [2:0] REG_ALT_IDX      = 3'(mevq_pkg::REG_ALT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t              state_reg;
    logic [SW-1:0]       occ_reg;
    logic [SW-1:0]       step_reg;
    logic [SW-1:0]       k_reg;
    logic                found_reg;
    logic                is_get_reg;
    logic [31:0]         mask_reg;
    mevq_pkg::entry_t    hit_reg;
    logic                rep_valid_reg;
    logic [SW-1:0]       rep_id_reg;
    logic [31:0]         held_reg;
    logic                out_valid_reg;
    mevq_pkg::out_item_t out_reg;
    logic [31:0]         key_down_reg;
    logic [31:0]         key_rep_reg;
    logic [31:0]         shift_bit_reg;
    logic [31:0]         ctrl_bit_reg;
    logic [31:0]         alt_bit_reg;
    logic [SW-1:0]       fs_reg [QUEUE_DEPTH];

    mevq_pkg::entry_t    cells [QUEUE_DEPTH];
    mevq_pkg::entry_t    fresh;
    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                has_room;
    logic                is_post;
    logic                is_find;
    logic                do_append;
    logic                do_incr;
    logic                do_rotate;
    logic                do_remove;
    logic                mod_key;
    logic [31:0]         mod_bit;
    logic [31:0]         held_upd;
    logic [31:0]         sym;
    logic                hit;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg  <= 32'd1;
            key_rep_reg   <= 32'd2;
            shift_bit_reg <= 32'd64;
            ctrl_bit_reg  <= 32'd128;
            alt_bit_reg   <= 32'd256;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_KEY_DOWN_IDX: key_down_reg  <= pwdata;
                REG_KEY_REP_IDX:  key_rep_reg   <= pwdata;
                REG_SHIFT_IDX:    shift_bit_reg <= pwdata;
                REG_CTRL_IDX:     ctrl_bit_reg  <= pwdata;
                REG_ALT_IDX:      alt_bit_reg   <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_KEY_DOWN_IDX: prdata = key_down_reg;
            REG_KEY_REP_IDX:  prdata = key_rep_reg;
            REG_SHIFT_IDX:    prdata = shift_bit_reg;
            REG_CTRL_IDX:     prdata = ctrl_bit_reg;
            REG_ALT_IDX:      prdata = alt_bit_reg;
            default:          prdata = 32'd0;
        endcase
    end

    // handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // post decode
    assign sym      = in_data.payload;
    assign has_room = occ_reg < Depth;
    assign is_post  = (in_data.operation == 3'(mevq_pkg::OP_RAW))
                   || (in_data.operation == 3'(mevq_pkg::OP_KEY))
                   || (in_data.operation == 3'(mevq_pkg::OP_MOUSE));
    assign is_find  = (in_data.operation == 3'(mevq_pkg::OP_GET))
                   || (in_data.operation == 3'(mevq_pkg::OP_PEEK));
    assign out_load = ((state_reg == ST_IDLE) && accept && !is_find)
                   || ((state_reg == ST_FIN) && out_free);

    always_comb
    begin
        mod_key = 1'b1;
        priority if (sym == 32'hffe1 || sym == 32'hffe2)
            mod_bit = shift_bit_reg;
        else if (sym == 32'hffe3 || sym == 32'hffe4)
            mod_bit = ctrl_bit_reg;
        else if (sym == 32'hffe9 || sym == 32'hffea)
            mod_bit = alt_bit_reg;
        else
        begin
            mod_bit = 32'd0;
            mod_key = 1'b0;
        end
        if (!mod_key)
            held_upd = held_reg;
        else if (in_data.event_type == key_down_reg)
            held_upd = held_reg | mod_bit;
        else
            held_upd = held_reg & ~mod_bit;
    end

    always_comb
    begin
        fresh = '0;
        fresh.id    = fs_reg[0];
        fresh.etype = in_data.event_type;
        fresh.stamp = in_data.timestamp;
        do_incr     = 1'b0;
        do_append   = 1'b0;
        if (accept && has_room)
        begin
            unique case (in_data.operation)
                3'(mevq_pkg::OP_RAW):
                begin
                    do_append  = 1'b1;
                    fresh.src  = in_data.source_id;
                    fresh.msg  = in_data.payload;
                    fresh.mods = in_data.modifier_bits;
                end
                3'(mevq_pkg::OP_KEY):
                begin
                    fresh.msg  = mevq_pkg::RepeatStep | {24'd0, sym[7:0]};
                    fresh.mods = held_upd;
                    if ((in_data.event_type == key_rep_reg) && rep_valid_reg)
                        do_incr = 1'b1;
                    else
                        do_append = 1'b1;
                end
                3'(mevq_pkg::OP_MOUSE):
                begin
                    do_append  = 1'b1;
                    fresh.mods = in_data.modifier_bits | held_reg;
                    fresh.x    = in_data.pos_x;
                    fresh.y    = in_data.pos_y;
                end
                default: ;
            endcase
        end
    end

    assign do_rotate = (state_reg == ST_SCAN);
    assign do_remove = (state_reg == ST_FIN) && out_free && found_reg && is_get_reg;
    assign hit = !found_reg && (step_reg < occ_reg) && ((cells[0].etype & mask_reg) != 32'd0);

    // chain of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        mevq_pkg::cell_ctl_t ctl;

        assign ctl.shift = do_rotate || (do_remove && (SW'(i) >= k_reg));
        assign ctl.load  = do_append && (SW'(i) == occ_reg);
        assign ctl.incr  = do_incr;

        mevq_cell u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .nbr    (cells[(i + 1) % QUEUE_DEPTH]),
            .fresh  (fresh),
            .rep_id (rep_id_reg),
            .entry  (cells[i])
        );

        // free slot stack
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fs_reg[i] <= SW'(i);
            end
            else if (do_append)
            begin
                if (i < QUEUE_DEPTH - 1)
                    fs_reg[i] <= fs_reg[(i + 1) % QUEUE_DEPTH];
            end
            else if (do_remove)
            begin
                if (i == 0)
                    fs_reg[i] <= hit_reg.id;
                else
                    fs_reg[i] <= fs_reg[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            step_reg      <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            is_get_reg    <= 1'b0;
            mask_reg      <= '0;
            rep_valid_reg <= 1'b0;
            rep_id_reg    <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            hit_reg       <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_find)
                        begin
                            state_reg  <= ST_SCAN;
                            step_reg   <= '0;
                            found_reg  <= 1'b0;
                            mask_reg   <= in_data.type_mask;
                            is_get_reg <= (in_data.operation == 3'(mevq_pkg::OP_GET));
                        end
                        else
                        begin
                            out_reg <= '{success: (is_post && has_room), default: '0};
                            if (is_post && has_room
                                && (in_data.operation == 3'(mevq_pkg::OP_KEY)))
                            begin
                                held_reg <= held_upd;
                                if ((in_data.event_type == key_rep_reg) && !rep_valid_reg)
                                begin
                                    rep_valid_reg <= 1'b1;
                                    rep_id_reg    <= fs_reg[0];
                                end
                            end
                            if (do_append)
                                occ_reg <= occ_reg + SW'(1);
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                        k_reg     <= step_reg;
                        hit_reg   <= cells[0];
                    end
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == LastIdx)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                        if (found_reg)
                            out_reg <= '{success:       1'b1,
                                         out_source_id: hit_reg.src,
                                         out_type:      hit_reg.etype,
                                         out_message:   hit_reg.msg,
                                         out_modifiers: hit_reg.mods,
                                         out_x:         hit_reg.x,
                                         out_y:         hit_reg.y,
                                         out_time:      hit_reg.stamp};
                        else
                            out_reg <= '0;
                        if (do_remove)
                        begin
                            occ_reg <= occ_reg - SW'(1);
                            if (hit_reg.etype == key_rep_reg)
                                rep_valid_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= Depth)
        else $error("occupancy above depth");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_post && (occ_reg == Depth)) |=> (out_valid && !out_data.success))
        else $error("post into full store accepted");

    a_remove_found: assert property (@(posedge clk) disable iff (!rst_n)
        do_remove |=> (occ_reg == $past(occ_reg) - SW'(1)))
        else $error("get did not unlink an entry");

    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && step_reg == LastIdx) |=> (state_reg == ST_FIN))
        else $error("scan did not end after one pass");

endmodule
